// ===== rtl/bgc_pkg.sv =====
// Shared types, codes and reset values for the button gesture classifier.
package bgc_pkg;

  localparam int TIME_W = 32;
  localparam int WIN_W  = 16;
  localparam int ADDR_W = 3;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CODE_IDLE    = 3'd0,
    CODE_PUSHING = 3'd1,
    CODE_LPRESS  = 3'd2,
    CODE_SHORT   = 3'd3,
    CODE_LONG    = 3'd4,
    CODE_VLONG   = 3'd5,
    CODE_DOUBLE  = 3'd6
  } code_t;

  typedef enum logic [ADDR_W-1:0] {
    REG_DISABLED    = 3'd0,
    REG_DBL_WINDOW  = 3'd1,
    REG_LPRESS_TIME = 3'd2,
    REG_LONG_MIN    = 3'd3,
    REG_VLONG_MIN   = 3'd4,
    REG_SETTLE_TIME = 3'd5
  } reg_addr_t;

  // gesture bit positions
  localparam logic [3:0] BIT_SHORT  = 4'h1;
  localparam logic [3:0] BIT_LONG   = 4'h2;
  localparam logic [3:0] BIT_VLONG  = 4'h4;
  localparam logic [3:0] BIT_DOUBLE = 4'h8;

  localparam logic [WIN_W-1:0] RST_DBL_WINDOW  = 16'd300;
  localparam logic [WIN_W-1:0] RST_LPRESS_TIME = 16'd1000;
  localparam logic [WIN_W-1:0] RST_LONG_MIN    = 16'd1000;
  localparam logic [WIN_W-1:0] RST_VLONG_MIN   = 16'd3000;
  localparam logic [WIN_W-1:0] RST_SETTLE_TIME = 16'd300;

  typedef struct packed {
    logic             disabled;
    logic [WIN_W-1:0] double_click_window;
    logic [WIN_W-1:0] long_press_time;
    logic [WIN_W-1:0] long_click_min;
    logic [WIN_W-1:0] very_long_click_min;
    logic [WIN_W-1:0] short_settle_time;
  } cfg_t;

endpackage

// ===== rtl/button_gesture_classifier.sv =====
// Top level of the button gesture classifier: input register, classifier, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: cmd, pressed, now_ms.
//   cmd 0 samples the button level, cmd 1 clears code and event, cmd 2 reads
//   and clears the event flag. Every request yields exactly one result on the
//   output channel (out_valid / out_stall): gesture_code and event_flag.
//   A request is taken at a clock edge with valid high and stall low.
//   A request accepted into the input register is classified as it moves on
//   into the result register, where its result becomes visible. Throughput:
//   one request per cycle while the receiver does not stall, set by the single
//   classifier pass between the two registers; the gesture state updates as
//   the request moves into the result register.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, then in_stall rises until the result drains.
//   Configuration: cfg_valid / cfg_ready with cfg_addr and cfg_data; cfg_ready
//   is always high. Write only while no request is in flight.
//   Reset (rst, synchronous): both registers empty, configuration at defaults,
//   gesture state released with code idle and no event pending.
module button_gesture_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic                       pressed,
  input  logic [bgc_pkg::TIME_W-1:0] now_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 gesture_code,
  output logic                       event_flag,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [bgc_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [bgc_pkg::WIN_W-1:0]  cfg_data
);

  bgc_pkg::cfg_t cfg;

  // input register
  logic                       s1_valid;
  logic [1:0]                 s1_cmd;
  logic                       s1_pressed;
  logic [bgc_pkg::TIME_W-1:0] s1_now;

  logic       advance;
  logic [2:0] code_next;
  logic       flag_next;

  assign cfg_ready = 1'b1;

  bgc_cfg_regs u_cfg (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_valid && cfg_ready),
    .addr  (cfg_addr),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // advance when the result register is empty or being drained this cycle
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_cmd     <= cmd;
      s1_pressed <= pressed;
      s1_now     <= now_ms;
    end
  end

  bgc_classifier u_cls (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .fire      (advance),
    .cmd       (s1_cmd),
    .pressed   (s1_pressed),
    .now_ms    (s1_now),
    .code_next (code_next),
    .flag_next (flag_next)
  );

  // result register: load on advance, hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      gesture_code <= code_next;
      event_flag   <= flag_next;
    end
  end

endmodule

// ===== rtl/bgc_cfg_regs.sv =====
// Configuration register file for the button gesture classifier.
module bgc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [bgc_pkg::ADDR_W-1:0] addr,
  input  logic [bgc_pkg::WIN_W-1:0]  data,
  output bgc_pkg::cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disabled            <= 1'b0;
      cfg.double_click_window <= bgc_pkg::RST_DBL_WINDOW;
      cfg.long_press_time     <= bgc_pkg::RST_LPRESS_TIME;
      cfg.long_click_min      <= bgc_pkg::RST_LONG_MIN;
      cfg.very_long_click_min <= bgc_pkg::RST_VLONG_MIN;
      cfg.short_settle_time   <= bgc_pkg::RST_SETTLE_TIME;
    end else if (wr_en) begin
      // drop writes to unmapped addresses
      unique case (addr)
        bgc_pkg::REG_DISABLED:    cfg.disabled            <= data[0];
        bgc_pkg::REG_DBL_WINDOW:  cfg.double_click_window <= data;
        bgc_pkg::REG_LPRESS_TIME: cfg.long_press_time     <= data;
        bgc_pkg::REG_LONG_MIN:    cfg.long_click_min      <= data;
        bgc_pkg::REG_VLONG_MIN:   cfg.very_long_click_min <= data;
        bgc_pkg::REG_SETTLE_TIME: cfg.short_settle_time   <= data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/bgc_classifier.sv =====
// Gesture state registers and the per-request classification logic.
module bgc_classifier (
  input  logic                       clk,
  input  logic                       rst,
  input  bgc_pkg::cfg_t              cfg,
  input  logic                       fire,
  input  logic [1:0]                 cmd,
  input  logic                       pressed,
  input  logic [bgc_pkg::TIME_W-1:0] now_ms,
  output logic [2:0]                 code_next,
  output logic                       flag_next
);

  logic                       last_level, last_level_next;
  logic [3:0]                 gesture_bits, gesture_bits_next;
  logic                       double_guess, double_guess_next;
  logic                       long_guess, long_guess_next;
  logic [bgc_pkg::TIME_W-1:0] press_stamp, press_stamp_next;
  logic [bgc_pkg::TIME_W-1:0] release_stamp, release_stamp_next;
  logic [2:0]                 latched_code, latched_code_next;
  logic                       event_pending, event_pending_next;

  logic [bgc_pkg::TIME_W-1:0] since_release, held;
  logic                       rise, fall;

  assign since_release = now_ms - release_stamp;
  assign held          = now_ms - press_stamp;
  assign rise          = pressed && !last_level;
  assign fall          = !pressed && last_level;

  always_comb begin
    last_level_next    = last_level;
    gesture_bits_next  = gesture_bits;
    double_guess_next  = double_guess;
    long_guess_next    = long_guess;
    press_stamp_next   = press_stamp;
    release_stamp_next = release_stamp;
    latched_code_next  = latched_code;
    event_pending_next = event_pending;
    flag_next          = event_pending;

    case (cmd)
      bgc_pkg::CMD_SAMPLE: begin
        if (!cfg.disabled) begin
          last_level_next = pressed;
          if (!event_pending) begin
            if (rise) begin
              press_stamp_next  = now_ms;
              double_guess_next =
                (since_release <= {16'd0, cfg.double_click_window});
              gesture_bits_next = 4'h0;
              latched_code_next = bgc_pkg::CODE_PUSHING;
            end else if (fall) begin
              release_stamp_next = now_ms;
              if (double_guess && !(|(gesture_bits & (bgc_pkg::BIT_LONG |
                                                       bgc_pkg::BIT_VLONG)))) begin
                gesture_bits_next  = gesture_bits | bgc_pkg::BIT_DOUBLE;
                latched_code_next  = bgc_pkg::CODE_DOUBLE;
                event_pending_next = 1'b1;
              end
            end else if (pressed) begin
              if (!double_guess && !(|(gesture_bits & (bgc_pkg::BIT_LONG |
                                                        bgc_pkg::BIT_VLONG)))) begin
                if (held >= {16'd0, cfg.long_press_time} && !long_guess) begin
                  long_guess_next    = 1'b1;
                  latched_code_next  = bgc_pkg::CODE_LPRESS;
                  event_pending_next = 1'b1;
                end
              end else begin
                latched_code_next = bgc_pkg::CODE_PUSHING;
              end
            end else begin
              if (!double_guess && !(|(gesture_bits & (bgc_pkg::BIT_SHORT |
                                                        bgc_pkg::BIT_LONG |
                                                        bgc_pkg::BIT_VLONG)))) begin
                if (!long_guess) begin
                  if (since_release > {16'd0, cfg.short_settle_time}) begin
                    gesture_bits_next  = gesture_bits | bgc_pkg::BIT_SHORT;
                    latched_code_next  = bgc_pkg::CODE_SHORT;
                    event_pending_next = 1'b1;
                  end
                end else begin
                  long_guess_next    = 1'b0;
                  event_pending_next = 1'b1;
                  // a hold below the long minimum also counts as very long
                  if (held >= {16'd0, cfg.long_click_min} &&
                      held <  {16'd0, cfg.very_long_click_min}) begin
                    gesture_bits_next = gesture_bits | bgc_pkg::BIT_LONG;
                    latched_code_next = bgc_pkg::CODE_LONG;
                  end else begin
                    gesture_bits_next = gesture_bits | bgc_pkg::BIT_VLONG;
                    latched_code_next = bgc_pkg::CODE_VLONG;
                  end
                end
              end else begin
                latched_code_next = bgc_pkg::CODE_IDLE;
              end
            end
          end
        end
        flag_next = event_pending_next;
      end
      bgc_pkg::CMD_CLEAR: begin
        event_pending_next = 1'b0;
        latched_code_next  = bgc_pkg::CODE_IDLE;
        flag_next          = 1'b0;
      end
      bgc_pkg::CMD_READ: begin
        event_pending_next = 1'b0;
      end
      default: ;
    endcase
  end

  assign code_next = latched_code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b0;
      gesture_bits  <= bgc_pkg::BIT_SHORT;
      double_guess  <= 1'b0;
      long_guess    <= 1'b0;
      press_stamp   <= '0;
      release_stamp <= '0;
      latched_code  <= bgc_pkg::CODE_IDLE;
      event_pending <= 1'b0;
    end else if (fire) begin
      last_level    <= last_level_next;
      gesture_bits  <= gesture_bits_next;
      double_guess  <= double_guess_next;
      long_guess    <= long_guess_next;
      press_stamp   <= press_stamp_next;
      release_stamp <= release_stamp_next;
      latched_code  <= latched_code_next;
      event_pending <= event_pending_next;
    end
  end

  a_clear_drops_event: assert property (@(posedge clk) disable iff (rst)
    fire && cmd == bgc_pkg::CMD_CLEAR |=> !event_pending &&
      latched_code == bgc_pkg::CODE_IDLE)
    else $error("clear request left event or code set");

  a_pending_freezes: assert property (@(posedge clk) disable iff (rst)
    fire && cmd == bgc_pkg::CMD_SAMPLE && event_pending |=>
      event_pending && $stable(latched_code) && $stable(press_stamp))
    else $error("sample changed gesture while event pending");

  a_disabled_frozen: assert property (@(posedge clk) disable iff (rst)
    fire && cmd == bgc_pkg::CMD_SAMPLE && cfg.disabled |=>
      $stable(last_level) && $stable(gesture_bits) && $stable(event_pending))
    else $error("disabled sample changed state");

  a_event_has_gesture: assert property (@(posedge clk) disable iff (rst)
    $rose(event_pending) |-> latched_code != bgc_pkg::CODE_IDLE &&
      latched_code != bgc_pkg::CODE_PUSHING)
    else $error("event raised without a reported gesture");

  a_reset_state: assert property (@(posedge clk)
    rst |=> gesture_bits == bgc_pkg::BIT_SHORT && !event_pending && !long_guess)
    else $error("state not cleared by reset");

endmodule
